/* hdl/iiee_pkg.sv */
`timescale 1ns / 1ps

package iiee_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [7:0]             char_t;

  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_MUL   = 8'h2A;
  localparam char_t CH_DIV   = 8'h2F;
  localparam char_t CH_ADD   = 8'h2B;
  localparam char_t CH_SUB   = 8'h2D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam int    RADIX    = 10;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } md_rsp_t;

endpackage

/* hdl/iiee_in_if.sv */
`timescale 1ns / 1ps

interface iiee_in_if;
  import iiee_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

/* hdl/iiee_out_if.sv */
`timescale 1ns / 1ps

interface iiee_out_if;
  import iiee_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  logic                        div_by_zero;
  logic                        bad_character;

  modport source (output valid, output value, output div_by_zero, output bad_character,
                  input ready);
  modport sink (input valid, input value, input div_by_zero, input bad_character,
                output ready);
endinterface

/* hdl/infix_integer_expression_evaluator.sv */
`timescale 1ns / 1ps

// Evaluates an infix integer expression fed one ASCII character per request on chars.
// Digits build a decimal operand, spaces are skipped, * and / bind tighter than + and -,
// division truncates toward zero and all arithmetic wraps at 32 bits. An '=' returns one
// result on results with the value and sticky flags for a zero divisor and for an unknown
// character, then clears for the next expression. Digits, spaces and unknown characters are
// taken while idle; an operator is registered and applied in a post state, after waiting
// for a multiply or divide that it closes, which runs one bit per cycle on a single shared
// shift-add/subtract unit (a divide by zero skips the run). An '=' can wait further while an
// earlier result has not been taken; other characters are taken while a result waits.
module infix_integer_expression_evaluator (
  input logic         clk,
  input logic         rst,
  iiee_in_if.sink     chars,
  iiee_out_if.source  results
);
  import iiee_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_POST
  } state_t;

  typedef enum logic [1:0] {
    TOP_NONE,
    TOP_MUL,
    TOP_DIV
  } term_op_t;

  state_t   state;
  char_t    op_char;
  value_t   acc;
  value_t   term;
  term_op_t term_op;
  value_t   sum;
  logic     sign;
  logic     dz_flag;
  logic     bad_flag;

  logic                        out_valid;
  logic signed [OUT_WIDTH-1:0] out_value;
  logic                        out_dz;
  logic                        out_bad;

  md_req_t  md_req;
  md_rsp_t  md_rsp;
  value_t   md_result;

  logic     accept;
  logic     is_digit;
  logic     is_op;
  char_t    digit;
  value_t   acc_next;
  value_t   sum_next;
  logic     out_free;
  logic     emit;

  assign accept   = chars.valid && chars.ready;
  assign is_digit = (chars.character >= CH_ZERO) && (chars.character <= CH_NINE);
  assign is_op    = (chars.character == CH_MUL) || (chars.character == CH_DIV) ||
                    (chars.character == CH_ADD) || (chars.character == CH_SUB) ||
                    (chars.character == CH_EQ);
  assign digit    = chars.character - CH_ZERO;
  assign acc_next = (acc << 3) + (acc << 1) + VALUE_WIDTH'(digit);
  assign sum_next = sign ? (sum - term) : (sum + term);
  assign out_free = !out_valid || results.ready;
  assign emit     = (state == S_POST) && (op_char == CH_EQ) && out_free;

  assign md_req.start = accept && is_op && (term_op != TOP_NONE);
  assign md_req.op    = (term_op == TOP_MUL) ? MD_MUL : MD_DIV;

  assign chars.ready           = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.value         = out_value;
  assign results.div_by_zero   = out_dz;
  assign results.bad_character = out_bad;

  iiee_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (term),
    .b      (acc),
    .rsp    (md_rsp),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_char   <= CH_SPACE;
      acc       <= '0;
      term      <= '0;
      term_op   <= TOP_NONE;
      sum       <= '0;
      sign      <= 1'b0;
      dz_flag   <= 1'b0;
      bad_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_digit) begin
              acc <= acc_next;
            end else if (is_op) begin
              op_char <= chars.character;
              acc     <= '0;
              if (term_op == TOP_NONE) begin
                term  <= acc;
                state <= S_POST;
              end else begin
                state <= S_WAIT;
              end
            end else if (chars.character != CH_SPACE) begin
              bad_flag <= 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (md_rsp.done) begin
            term    <= md_result;
            dz_flag <= dz_flag | md_rsp.div_zero;
            state   <= S_POST;
          end
        end
        S_POST: begin
          case (op_char)
            CH_MUL: begin
              term_op <= TOP_MUL;
              state   <= S_IDLE;
            end
            CH_DIV: begin
              term_op <= TOP_DIV;
              state   <= S_IDLE;
            end
            CH_ADD, CH_SUB: begin
              sum     <= sum_next;
              term    <= '0;
              term_op <= TOP_NONE;
              sign    <= (op_char == CH_SUB);
              state   <= S_IDLE;
            end
            CH_EQ: begin
              // end of expression: emit and clear
              if (out_free) begin
                out_valid <= 1'b1;
                out_value <= OUT_WIDTH'(signed'(sum_next));
                out_dz    <= dz_flag;
                out_bad   <= bad_flag;
                acc       <= '0;
                term      <= '0;
                term_op   <= TOP_NONE;
                sum       <= '0;
                sign      <= 1'b0;
                dz_flag   <= 1'b0;
                bad_flag  <= 1'b0;
                state     <= S_IDLE;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/iiee_muldiv.sv */
`timescale 1ns / 1ps

module iiee_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  iiee_pkg::md_req_t req,
  input  iiee_pkg::value_t  a,
  input  iiee_pkg::value_t  b,
  output iiee_pkg::md_rsp_t rsp,
  output iiee_pkg::value_t  result
);
  import iiee_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t               state;
  md_op_t               op;
  logic [CNT_W-1:0]     cnt;
  value_t               rem;
  value_t               quo;
  value_t               den;
  logic                 neg;
  logic                 dz;

  value_t               a_mag;
  value_t               b_mag;
  logic [VALUE_WIDTH+1:0] diff;

  assign a_mag = a[VALUE_WIDTH-1] ? -a : a;
  assign b_mag = b[VALUE_WIDTH-1] ? -b : b;
  assign diff  = {1'b0, rem, quo[VALUE_WIDTH-1]} - {2'b00, den};

  assign rsp.done     = (state == S_DONE);
  assign rsp.div_zero = dz;
  assign result       = (op == MD_MUL) ? rem : (neg ? -quo : quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= MD_MUL;
      dz    <= 1'b0;
      neg   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            cnt <= '0;
            dz  <= 1'b0;
            rem <= '0;
            if (req.op == MD_MUL) begin
              quo   <= b;
              den   <= a;
              neg   <= 1'b0;
              state <= S_RUN;
            end else if (b == '0) begin
              quo   <= '0;
              den   <= '0;
              neg   <= 1'b0;
              dz    <= 1'b1;
              state <= S_DONE;
            end else begin
              quo   <= a_mag;
              den   <= b_mag;
              neg   <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (op == MD_MUL) begin
            rem <= rem + (quo[0] ? den : '0);
            den <= {den[VALUE_WIDTH-2:0], 1'b0};
            quo <= {1'b0, quo[VALUE_WIDTH-1:1]};
          end else if (!diff[VALUE_WIDTH+1]) begin
            rem <= diff[VALUE_WIDTH-1:0];
            quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            rem <= {rem[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};
            quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/infix_integer_expression_evaluator_tb.sv */
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_tb;
  import iiee_pkg::*;

  localparam int LIMIT_CYCLES   = 600000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_CHARS   = 1000;
  localparam int NOISE_CHARS    = 120;

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_MUL,
    TERM_DIV
  } term_op_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        div_by_zero;
    logic                        bad_character;
  } expr_result_t;

  logic clk;
  logic rst;

  iiee_in_if  chars_if ();
  iiee_out_if results_if ();

  infix_integer_expression_evaluator dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  // expression state mirror
  value_t   operand_acc;
  value_t   term_acc;
  term_op_t term_op;
  value_t   sum_acc;
  logic     sum_subtract;
  logic     div_zero_seen;
  logic     bad_char_seen;

  expr_result_t pending_results[$];

  int  errors;
  int  chars_sent;
  int  cycles;
  bit  quiet;
  bit  hold_results;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_expression();
    operand_acc   = '0;
    term_acc      = '0;
    term_op       = TERM_NONE;
    sum_acc       = '0;
    sum_subtract  = 1'b0;
    div_zero_seen = 1'b0;
    bad_char_seen = 1'b0;
  endfunction

  // signed quotient truncated toward zero, zero divisor gives zero
  function automatic value_t trunc_quotient(value_t a, value_t b);
    value_t ma;
    value_t mb;
    value_t q;
    ma = a[VALUE_WIDTH-1] ? -a : a;
    mb = b[VALUE_WIDTH-1] ? -b : b;
    if (mb == '0) begin
      div_zero_seen = 1'b1;
      return '0;
    end
    q = ma / mb;
    return (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) ? -q : q;
  endfunction

  function automatic void close_operand();
    case (term_op)
      TERM_MUL: term_acc = term_acc * operand_acc;
      TERM_DIV: term_acc = trunc_quotient(term_acc, operand_acc);
      default:  term_acc = operand_acc;
    endcase
    operand_acc = '0;
  endfunction

  function automatic void close_term();
    sum_acc  = sum_subtract ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc = '0;
    term_op  = TERM_NONE;
  endfunction

  function automatic void evaluate_char(char_t c);
    expr_result_t r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      operand_acc = operand_acc * value_t'(RADIX) + value_t'(c - CH_ZERO);
      return;
    end
    case (c)
      CH_SPACE: ;
      CH_MUL, CH_DIV: begin
        close_operand();
        term_op = (c == CH_MUL) ? TERM_MUL : TERM_DIV;
      end
      CH_ADD, CH_SUB: begin
        close_operand();
        close_term();
        sum_subtract = (c == CH_SUB);
      end
      CH_EQ: begin
        close_operand();
        close_term();
        r.value         = $signed(sum_acc);
        r.div_by_zero   = div_zero_seen;
        r.bad_character = bad_char_seen;
        pending_results.push_back(r);
        clear_expression();
      end
      default: bad_char_seen = 1'b1;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : check_results
    expr_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d dz=%0b bad=%0b", $time,
                 results_if.value, results_if.div_by_zero, results_if.bad_character);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (results_if.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value,
                   results_if.value);
          errors++;
        end
        if (results_if.div_by_zero !== want.div_by_zero) begin
          $display("%0t: div_by_zero expected %0b actual %0b", $time, want.div_by_zero,
                   results_if.div_by_zero);
          errors++;
        end
        if (results_if.bad_character !== want.bad_character) begin
          $display("%0t: bad_character expected %0b actual %0b", $time,
                   want.bad_character, results_if.bad_character);
          errors++;
        end
      end
    end
  end

  initial begin : drive_result_ready
    int stall_left;
    stall_left = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        results_if.ready <= 1'b0;
        hold_results = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        results_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_char(input char_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.character <= c;
    do @(posedge clk); while (!chars_if.ready);
    evaluate_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(char_t'(s[i]));
    end
  endtask

  task automatic finish_test();
    chars_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_number();
    int kind;
    int digits;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      send_char(CH_ZERO);
    end else if (kind < 94) begin
      digits = (kind < 50) ? 1 : (kind < 78) ? $urandom_range(2, 4) : $urandom_range(5, 10);
      send_char(CH_ZERO + char_t'($urandom_range(1, 9)));
      for (int i = 1; i < digits; i++) begin
        send_char(CH_ZERO + char_t'($urandom_range(0, 9)));
      end
    end else begin
      case ($urandom_range(0, 4))
        0: send_text("2147483647");
        1: send_text("2147483648");
        2: send_text("4294967295");
        3: send_text("4294967296");
        default: send_text("9999999999");
      endcase
    end
  endtask

  task automatic send_random_expression();
    int    terms;
    char_t ops[4];
    ops = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};
    terms = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) begin
      send_char($urandom_range(0, 1) ? CH_SUB : CH_ADD);
    end
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(0, 99) >= 4) begin
        send_number();
      end
      if ($urandom_range(0, 99) < 3) begin
        send_char(char_t'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 15) begin
        send_char(CH_SPACE);
      end
      if (t < terms - 1) begin
        send_char(ops[$urandom_range(0, 3)]);
      end
    end
    send_char(CH_EQ);
  endtask

  task automatic test_directed_cases();
    send_text("2147483647+1=");
    send_text("4294967296=");
    send_text("2147483648/4294967295=");
    send_text("7/0+3=");
    send_text("-7/2=");
    send_text("7/4294967294=");
    send_text("0*5-0=");
    send_text(" 1 + 2 * 3 =");
    send_text("1a+2=");
    send_text("=");
    send_text("+*5--3=");
    send_text("65536*65536-1=");
    send_text("100/7*7/0+9=");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("12*34/5-6=");
    finish_test();
  endtask

  // results held off while the sender keeps going so the input backs up
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_results = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_text("3*4-5=");
    end
    quiet = 1'b0;
    finish_test();
  endtask

  task automatic test_random_expressions();
    int target;
    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) begin
      quiet = ($urandom_range(0, 9) == 0);
      send_random_expression();
    end
    quiet = 1'b0;
    finish_test();
  endtask

  task automatic test_random_noise();
    for (int i = 0; i < NOISE_CHARS; i++) begin
      send_char(char_t'($urandom_range(0, 255)));
    end
    send_char(CH_EQ);
    finish_test();
  endtask

  initial begin
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.character = '0;
    errors             = 0;
    chars_sent         = 0;
    cycles             = 0;
    quiet              = 1'b0;
    hold_results       = 1'b0;
    clear_expression();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_backpressure();
    test_random_expressions();
    test_random_noise();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
